// ===== rtl/core/cdfir_pkg.sv =====
// Shared constants and types of the complex decimating FIR stage.
package cdfir_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int ADDR_W      = $clog2(MAX_TAPS);
    localparam int CNT_W       = $clog2(MAX_TAPS + 1);
    localparam int SMP_W       = 16;
    localparam int PROD_W      = 2 * SMP_W;
    localparam int ACC_W       = 40;
    localparam int FRAC_W      = 15;
    localparam int TAP_IDX_W   = 6;
    localparam int DEC_W       = 8;
    localparam int TAPS_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_FIELDS_W = 3 * SMP_W + TAP_IDX_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 2 * SMP_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MAC   = 3'b010,
        ST_ROUND = 3'b100
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECIMATION = 2'd0,
        REG_TAPS       = 2'd1
    } cfg_reg_t;

endpackage

// ===== rtl/core/complex_decimating_fir.sv =====
// Top level of the complex decimating FIR stage with real coefficients.
// A word that ends no decimation period leaves s_axis_tready high.
// A period-ending sample starts a convolution: the delay and coefficient memories are read,
// multiplied and accumulated over min(taps_in_use, 64) taps by the single complex MAC, then rounded.
// s_axis_tready stays low until the result is loaded, which waits while the output is stalled.
// Reset clears the valid bits of both memories at once, so both read as zero; no clearing pass.
module complex_decimating_fir
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sample_re, sample_im, tap_index, tap_value, zero padding
    input  logic [cdfir_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_re, out_im
    output logic [cdfir_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdfir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cdfir_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cdfir_pkg::*;

    localparam int RND_W = ACC_W - FRAC_W + 1;

    state_t                    state_reg, state_next;
    logic [DEC_W-1:0]          dec_reg;
    logic [TAPS_W-1:0]         taps_reg;
    logic [DEC_W-1:0]          cnt_reg;
    logic [ADDR_W-1:0]         newest_reg;
    logic [CNT_W-1:0]          issue_reg;
    logic [MAX_TAPS-1:0]       dly_vld_reg;
    logic [MAX_TAPS-1:0]       coef_vld_reg;
    logic                      rd_vld_reg;
    logic                      mul_vld_reg;
    logic signed [ACC_W-1:0]   acc_re_reg, acc_im_reg;
    logic                      out_vld_reg;
    logic [OUT_DATA_W-1:0]     out_reg;

    logic [2*SMP_W-1:0]        dly_mem [MAX_TAPS];
    logic signed [SMP_W-1:0]   coef_mem [MAX_TAPS];
    logic [2*SMP_W-1:0]        rd_dly_reg;
    logic signed [SMP_W-1:0]   rd_coef_reg;
    logic                      rd_dly_ok_reg, rd_coef_ok_reg;
    logic signed [PROD_W-1:0]  mul_re_reg, mul_im_reg;

    logic                      in_acc;
    logic                      smp_wr;
    logic                      tap_wr;
    logic [ADDR_W-1:0]         wr_pos;
    logic [DEC_W-1:0]          cnt_dec;
    logic                      period_end;
    logic [CNT_W-1:0]          n_taps;
    logic                      issue_en;
    logic [ADDR_W-1:0]         rd_dly_addr;
    logic [ADDR_W-1:0]         rd_coef_addr;
    logic signed [SMP_W-1:0]   coef_eff, dly_re_eff, dly_im_eff;
    logic                      out_free;
    logic                      load_out;
    logic [TAP_IDX_W-1:0]      tap_idx;

    function automatic logic [SMP_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]   biased;
        logic signed [RND_W-1:0] rnd;
        biased = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (FRAC_W - 1));
        rnd    = biased[ACC_W:FRAC_W];
        if (rnd > RND_W'((1 << (SMP_W - 1)) - 1)) begin
            finish = {1'b0, {(SMP_W-1){1'b1}}};
        end else if (rnd < -RND_W'(1 << (SMP_W - 1))) begin
            finish = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            finish = rnd[SMP_W-1:0];
        end
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign smp_wr     = in_acc && !s_axis_tuser;
    assign tap_wr     = in_acc && s_axis_tuser;
    assign tap_idx    = s_axis_tdata[2*SMP_W +: TAP_IDX_W];
    assign wr_pos     = newest_reg + ADDR_W'(1);
    assign cnt_dec    = cnt_reg - DEC_W'(1);
    assign period_end = smp_wr && (cnt_dec == '0);

    assign n_taps       = (taps_reg > TAPS_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(taps_reg);
    assign issue_en     = (state_reg == ST_MAC) && (issue_reg < n_taps);
    assign rd_coef_addr = issue_reg[ADDR_W-1:0];
    assign rd_dly_addr  = newest_reg - issue_reg[ADDR_W-1:0];

    assign coef_eff   = rd_coef_ok_reg ? rd_coef_reg : '0;
    assign dly_re_eff = rd_dly_ok_reg ? rd_dly_reg[SMP_W-1:0] : '0;
    assign dly_im_eff = rd_dly_ok_reg ? rd_dly_reg[2*SMP_W-1:SMP_W] : '0;

    assign out_free = !out_vld_reg || m_axis_tready;
    assign load_out = (state_reg == ST_ROUND) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (period_end) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (!issue_en && !rd_vld_reg && !mul_vld_reg) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (smp_wr) begin
            dly_mem[wr_pos] <= s_axis_tdata[2*SMP_W-1:0];
        end
        if (tap_wr) begin
            coef_mem[tap_idx] <= s_axis_tdata[2*SMP_W+TAP_IDX_W +: SMP_W];
        end
        if (issue_en) begin
            rd_dly_reg     <= dly_mem[rd_dly_addr];
            rd_coef_reg    <= coef_mem[rd_coef_addr];
            rd_dly_ok_reg  <= dly_vld_reg[rd_dly_addr];
            rd_coef_ok_reg <= coef_vld_reg[rd_coef_addr];
        end
        mul_re_reg <= coef_eff * dly_re_eff;
        mul_im_reg <= coef_eff * dly_im_eff;
        if (load_out) begin
            out_reg <= {finish(acc_im_reg), finish(acc_re_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            dec_reg      <= DEC_W'(1);
            taps_reg     <= TAPS_W'(MAX_TAPS);
            cnt_reg      <= DEC_W'(1);
            newest_reg   <= '0;
            issue_reg    <= '0;
            dly_vld_reg  <= '0;
            coef_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            mul_vld_reg  <= 1'b0;
            acc_re_reg   <= '0;
            acc_im_reg   <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue_en;
            mul_vld_reg <= rd_vld_reg;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_DECIMATION:
                    begin
                        dec_reg <= cfg_data[DEC_W-1:0];
                        cnt_reg <= cfg_data[DEC_W-1:0];
                    end
                    REG_TAPS:
                    begin
                        taps_reg <= cfg_data[TAPS_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (smp_wr) begin
                newest_reg          <= wr_pos;
                dly_vld_reg[wr_pos] <= 1'b1;
                cnt_reg             <= period_end ? dec_reg : cnt_dec;
            end
            if (tap_wr) begin
                coef_vld_reg[tap_idx] <= 1'b1;
            end

            if (period_end) begin
                issue_reg  <= '0;
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end else begin
                if (issue_en) begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (mul_vld_reg) begin
                    acc_re_reg <= acc_re_reg + ACC_W'(mul_re_reg);
                    acc_im_reg <= acc_im_reg + ACC_W'(mul_im_reg);
                end
            end

            if (load_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/cdfir_checker.sv =====
// Port-level assertions for the complex decimating FIR stage, bound to its top level.
module cdfir_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [cdfir_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result word must hold its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // A coefficient write never starts a convolution.
    a_tap_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready)
        else $error("coefficient write blocked the input");

    // A new result only appears after the input has been held off for the convolution.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a convolution");

    // The input is released by the time a new result word appears.
    a_busy_before: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("input not released after the result was loaded");

endmodule

bind complex_decimating_fir cdfir_checker u_cdfir_checker (.*);

// ===== verif/complex_decimating_fir_tb.sv =====
// Self-checking testbench for the complex decimating FIR stage.
module complex_decimating_fir_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdfir_pkg::*;

    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_TAP_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int SETTLE_CYCLES = MAX_TAPS + 16;

    typedef struct {
        logic               op;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic [5:0]         tap_index;
        logic signed [15:0] tap_value;
    } fir_word_t;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
    } filtered_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [7:0]         decim_setting;
    logic [6:0]         active_taps;
    logic [7:0]         samples_to_output;
    logic [5:0]         newest_slot;
    logic signed [15:0] history_re [MAX_TAPS];
    logic signed [15:0] history_im [MAX_TAPS];
    logic signed [15:0] coefficients [MAX_TAPS];

    filtered_t expected_outputs [$];
    int        mismatch_count  = 0;
    int        hold_off_cycles = 0;
    bit        no_idling       = 1'b0;

    complex_decimating_fir dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [15:0] round_saturate(input logic signed [39:0] acc);
        logic signed [40:0] biased;
        logic signed [25:0] scaled;
        biased = acc + 41'sd16384;
        scaled = 26'(biased >>> FRAC_W);
        if (scaled > 26'sd32767)
        begin
            return 16'sh7fff;
        end
        if (scaled < -26'sd32768)
        begin
            return 16'sh8000;
        end
        return scaled[15:0];
    endfunction

    function automatic logic signed [15:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic clear_filter_model();
        decim_setting     = 8'd1;
        active_taps       = 7'd64;
        samples_to_output = 8'd1;
        newest_slot       = 6'd0;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            history_re[i]   = '0;
            history_im[i]   = '0;
            coefficients[i] = '0;
        end
    endtask

    task automatic predict_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        logic signed [39:0] acc_re;
        logic signed [39:0] acc_im;
        logic signed [31:0] prod_re;
        logic signed [31:0] prod_im;
        logic [5:0]         slot;
        int                 span;
        filtered_t          y;
        newest_slot             = newest_slot + 6'd1;
        history_re[newest_slot] = re;
        history_im[newest_slot] = im;
        samples_to_output       = samples_to_output - 8'd1;
        if (samples_to_output == 8'd0)
        begin
            samples_to_output = decim_setting;
            span   = (active_taps > MAX_TAPS) ? MAX_TAPS : int'(active_taps);
            acc_re = '0;
            acc_im = '0;
            for (int i = 0; i < span; i++)
            begin
                slot    = newest_slot - 6'(i);
                prod_re = coefficients[i] * history_re[slot];
                prod_im = coefficients[i] * history_im[slot];
                acc_re  = acc_re + prod_re;
                acc_im  = acc_im + prod_im;
            end
            y.re = round_saturate(acc_re);
            y.im = round_saturate(acc_im);
            expected_outputs.push_back(y);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            REG_DECIMATION:
            begin
                decim_setting     = value;
                samples_to_output = value;
            end
            REG_TAPS: active_taps = value[6:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input fir_word_t w);
        logic [IN_DATA_W-1:0] packed_word;
        packed_word = '0;
        packed_word[IN_FIELDS_W-1:0] = {w.tap_value, w.tap_index, w.sample_im, w.sample_re};
        if (!no_idling && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.op;
        s_axis_tdata  <= packed_word;
        do @(posedge clk); while (!s_axis_tready);
        if (w.op == OP_TAP_WRITE)
        begin
            coefficients[w.tap_index] = w.tap_value;
        end
        else
        begin
            predict_sample(w.sample_re, w.sample_im);
        end
    endtask

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        fir_word_t w;
        w.op        = OP_SAMPLE;
        w.sample_re = re;
        w.sample_im = im;
        w.tap_index = 6'($urandom);
        w.tap_value = 16'($urandom);
        send_word(w);
    endtask

    task automatic send_tap(input logic [5:0] index, input logic signed [15:0] value);
        fir_word_t w;
        w.op        = OP_TAP_WRITE;
        w.sample_re = 16'($urandom);
        w.sample_im = 16'($urandom);
        w.tap_index = index;
        w.tap_value = value;
        send_word(w);
    endtask

    task automatic wait_for_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
    endtask

    task automatic test_directed_extremes();
        send_tap(6'd63, 16'sh7fff);
        send_tap(6'd62, 16'shffff);
        send_tap(6'd0, 16'sh8000);
        wait_for_outputs();
        write_register(REG_TAPS, 8'd1);
        send_sample(16'sh8000, 16'sh7fff);
        send_tap(6'd0, 16'sh0001);
        send_sample(16'sh4000, 16'shc000);
        send_sample(16'shbfff, 16'sh4001);
        wait_for_outputs();
        write_register(REG_TAPS, 8'd64);
        send_tap(6'd1, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh0000, 16'shffff);
        send_sample(16'sh8000, 16'sh8000);
    endtask

    task automatic test_tap_count_limits();
        wait_for_outputs();
        write_register(REG_TAPS, 8'd0);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(pick_level(), pick_level());
        wait_for_outputs();
        write_register(REG_TAPS, 8'd100);
        send_sample(pick_level(), pick_level());
        send_sample(pick_level(), pick_level());
        wait_for_outputs();
        write_register(REG_TAPS, 8'hc1);
        send_sample(pick_level(), pick_level());
        wait_for_outputs();
        write_register(REG_SPARE_A, 8'hff);
        write_register(REG_SPARE_B, 8'h00);
        send_sample(pick_level(), pick_level());
        send_sample(pick_level(), pick_level());
        wait_for_outputs();
        write_register(REG_TAPS, 8'd64);
    endtask

    task automatic test_decimation_limits();
        wait_for_outputs();
        write_register(REG_TAPS, 8'd3);
        write_register(REG_DECIMATION, 8'd5);
        send_sample(pick_level(), pick_level());
        send_sample(pick_level(), pick_level());
        wait_for_outputs();
        // Rewriting the decimation restarts the count from the new value.
        write_register(REG_DECIMATION, 8'd3);
        repeat (3) send_sample(pick_level(), pick_level());
        wait_for_outputs();
        write_register(REG_DECIMATION, 8'd0);
        repeat (256) send_sample(pick_level(), pick_level());
        wait_for_outputs();
        write_register(REG_DECIMATION, 8'd1);
    endtask

    task automatic test_output_stall();
        wait_for_outputs();
        write_register(REG_DECIMATION, 8'd1);
        write_register(REG_TAPS, 8'd64);
        no_idling       = 1'b1;
        hold_off_cycles = 600;
        repeat (40) send_sample(pick_level(), pick_level());
        no_idling = 1'b0;
        wait_for_outputs();
    endtask

    task automatic run_mixed_words(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_tap(6'($urandom), pick_level());
            end
            else
            begin
                send_sample(pick_level(), pick_level());
            end
        end
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_len;
        logic [7:0] decim;
        logic [7:0] taps;
        sent = 0;
        while (sent < 80)
        begin
            wait_for_outputs();
            case ($urandom_range(0, 7))
                0: decim = 8'd1;
                1: decim = 8'($urandom_range(7, 255));
                default: decim = 8'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 7))
                0: taps = 8'd64;
                1: taps = 8'($urandom);
                default: taps = 8'($urandom_range(1, 12));
            endcase
            write_register(REG_DECIMATION, decim);
            write_register(REG_TAPS, taps);
            no_idling = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(20, 60);
            run_mixed_words(phase_len);
            sent += phase_len;
        end
        no_idling = 1'b0;
    endtask

    task automatic test_steady_tail();
        wait_for_outputs();
        write_register(REG_DECIMATION, 8'($urandom_range(1, 3)));
        write_register(REG_TAPS, 8'($urandom_range(1, 64)));
        no_idling = 1'b1;
        run_mixed_words(30);
    endtask

    initial
    begin : receiver_pacing
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (!no_idling && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : output_check
        filtered_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_outputs.size() == 0)
            begin
                report_mismatch("unexpected output word", m_axis_tdata[15:0], 16'hxxxx);
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (m_axis_tdata[15:0] !== want.re)
                begin
                    report_mismatch("out_re", m_axis_tdata[15:0], want.re);
                end
                if (m_axis_tdata[31:16] !== want.im)
                begin
                    report_mismatch("out_im", m_axis_tdata[31:16], want.im);
                end
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SAMPLE;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_DECIMATION;
        cfg_data      <= '0;
        clear_filter_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_extremes();
        test_tap_count_limits();
        test_decimation_limits();
        test_output_stall();
        test_random_traffic();
        test_steady_tail();
        wait_for_outputs();
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
